// File: hw/rtl/ubx_packet_framer_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef UBX_PACKET_FRAMER_MACROS_SVH
`define UBX_PACKET_FRAMER_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define UBX_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("framer assertion failed");

// Condition must never be true outside reset.
`define UBX_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("framer forbidden condition seen");

`endif

// File: hw/rtl/ubx_pkg.sv
// Types and constants of the packet framer.
`default_nettype none
package ubx_pkg;

  localparam int PACKET_LIMIT_DEF = 128;
  localparam int FIFO_DEPTH_DEF   = 4;
  localparam int HDR_BYTES        = 6;
  localparam int FRAME_OVERHEAD   = 8;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  // op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_STRAY    = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_packet;
    logic [1:0] status;
  } out_word_t;

  // One classified item: the bytes it emits, in order, and how to tag them.
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [2:0]      last_idx;
    logic            has_cks;
    logic [1:0]      status;
  } job_t;

endpackage
`default_nettype wire

// File: hw/rtl/ubx_packet_framer.sv
// Top level of the binary GPS packet framer.
`default_nettype none
// ubx_packet_framer turns start and payload words into a framed byte stream:
// two sync bytes, class, id, 16-bit length (low byte first), the payload bytes,
// then the two Fletcher checksum bytes A and B, summed over class through the
// last payload byte. Both sides behave as queues: an input word is taken when
// push_i is high and full_o low, a result word is taken when pop_i is high and
// empty_o low. The front stage takes one input word per cycle, updates the
// running sums and packet state, and files the bytes the word causes into a
// FIFO_DEPTH-entry job queue; it stalls only while that queue is full. The
// back stage delivers one result word per cycle from the head job while pop_i is
// high and the queue is not empty. A word yields 1 result for a plain payload
// byte or an error, 3 for the last payload byte, 6 for a start, 8 for a start
// with zero length; payload words sustain one per cycle while pop_i stays high.
// A start whose length plus the eight framing bytes exceeds PACKET_LIMIT gives
// one zero byte with status "too long" and closes any open packet; a payload
// byte with no packet open gives one zero byte with status "stray". Sync bytes
// are set through the write port (index 0 first, index 1 second) and should be
// changed only while the block is idle. There is no clearing pass after reset.
module ubx_packet_framer #(
  parameter int PACKET_LIMIT = ubx_pkg::PACKET_LIMIT_DEF,
  parameter int FIFO_DEPTH   = ubx_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire ubx_pkg::in_word_t in_i,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output ubx_pkg::out_word_t     out_o
);
  import ubx_pkg::*;

  job_t job_in, job_head;
  logic q_push, q_pop, q_full, q_empty;

  assign full_o = q_full;

  ubx_front #(
    .PACKET_LIMIT(PACKET_LIMIT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (job_in)
  );

  // job queue lets the front keep taking words while results wait
  ubx_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(job_head),
    .empty_o(q_empty)
  );

  ubx_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job_head),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/ubx_fifo.sv
// Small register FIFO between the framer front and back.
`default_nettype none
`include "ubx_packet_framer_macros.svh"
module ubx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_MAX);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `UBX_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CNT_MAX)
  `UBX_ASSERT(a_cnt_up, clk_i, rst_ni,
              (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
  `UBX_ASSERT(a_cnt_down, clk_i, rst_ni,
              (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))

endmodule
`default_nettype wire

// File: hw/rtl/ubx_front.sv
// Framer front: accepts words, tracks the open packet and its checksum.
`default_nettype none
module ubx_front #(
  parameter int PACKET_LIMIT = ubx_pkg::PACKET_LIMIT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            push_i,
  input  wire ubx_pkg::in_word_t in_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output ubx_pkg::job_t        q_job_o
);
  import ubx_pkg::*;

  // at the smallest limit only empty packets fit; keep the counter one bit wide
  localparam int LEFT_W = (PACKET_LIMIT > FRAME_OVERHEAD) ?
                          $clog2(PACKET_LIMIT - FRAME_OVERHEAD + 1) : 1;
  localparam logic [16:0] LIMIT = 17'(PACKET_LIMIT);

  logic [7:0]        sync_first_q, sync_second_q;
  logic              open_q, open_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [7:0]        sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic              accept;

  // header sums, one byte after the other
  logic [7:0] lo, hi, ha1, ha2, ha3, ha4, hb2, hb3, hb4;
  logic [7:0] da, db;
  logic       too_long;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  always_comb begin
    lo  = in_i.payload_len[7:0];
    hi  = in_i.payload_len[15:8];
    ha1 = in_i.msg_class;
    ha2 = ha1 + in_i.msg_id;
    hb2 = ha1 + ha2;
    ha3 = ha2 + lo;
    hb3 = hb2 + ha3;
    ha4 = ha3 + hi;
    hb4 = hb3 + ha4;
    da  = sum_a_q + in_i.data_byte;
    db  = sum_b_q + da;
    too_long = ({1'b0, in_i.payload_len} + 17'(FRAME_OVERHEAD)) > LIMIT;

    open_d  = open_q;
    left_d  = left_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    q_job_o = '0;

    if (in_i.op == OP_START) begin
      if (too_long) begin
        open_d         = 1'b0;
        left_d         = '0;
        q_job_o.status = STATUS_TOO_LONG;
      end else begin
        sum_a_d          = ha4;
        sum_b_d          = hb4;
        q_job_o.bytes[0] = sync_first_q;
        q_job_o.bytes[1] = sync_second_q;
        q_job_o.bytes[2] = in_i.msg_class;
        q_job_o.bytes[3] = in_i.msg_id;
        q_job_o.bytes[4] = lo;
        q_job_o.bytes[5] = hi;
        q_job_o.bytes[6] = ha4;
        q_job_o.bytes[7] = hb4;
        if (in_i.payload_len == '0) begin
          open_d           = 1'b0;
          left_d           = '0;
          q_job_o.has_cks  = 1'b1;
          q_job_o.last_idx = 3'(HDR_BYTES + 1);
        end else begin
          open_d           = 1'b1;
          left_d           = in_i.payload_len[LEFT_W-1:0];
          q_job_o.last_idx = 3'(HDR_BYTES - 1);
        end
      end
    end else if (!open_q) begin
      q_job_o.status = STATUS_STRAY;
    end else begin
      sum_a_d          = da;
      sum_b_d          = db;
      q_job_o.bytes[0] = in_i.data_byte;
      q_job_o.bytes[1] = da;
      q_job_o.bytes[2] = db;
      if (left_q <= LEFT_W'(1)) begin
        open_d           = 1'b0;
        left_d           = '0;
        q_job_o.has_cks  = 1'b1;
        q_job_o.last_idx = 3'd2;
      end else begin
        left_d = left_q - LEFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      open_q        <= 1'b0;
      left_q        <= '0;
      sum_a_q       <= '0;
      sum_b_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
          CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        open_q  <= open_d;
        left_q  <= left_d;
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ubx_back.sv
// Framer back: walks the queued job and hands out one byte per word.
`default_nettype none
`include "ubx_packet_framer_macros.svh"
module ubx_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ubx_pkg::job_t job_i,
  input  wire logic          q_empty_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output ubx_pkg::out_word_t out_o
);
  import ubx_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       take, at_last;

  assign empty_o = q_empty_i;
  assign take    = pop_i && !q_empty_i;
  assign at_last = (idx_q == job_i.last_idx);
  assign q_pop_o = take && at_last;

  always_comb begin
    out_o.out_byte      = job_i.bytes[idx_q];
    out_o.end_of_run    = at_last;
    out_o.end_of_packet = at_last && job_i.has_cks;
    out_o.status        = job_i.status;
    idx_d = idx_q;
    if (take) begin
      idx_d = at_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `UBX_ASSERT(a_idx_in_job, clk_i, rst_ni, !q_empty_i |-> (idx_q <= job_i.last_idx))
  `UBX_ASSERT(a_idx_step, clk_i, rst_ni, (take && !at_last) |=> (idx_q == $past(idx_q) + 3'd1))
  `UBX_ASSERT(a_idx_wrap, clk_i, rst_ni, (take && at_last) |=> (idx_q == 3'd0))

endmodule
`default_nettype wire
